// File: design/isoep_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the ISO 8601 timestamp to Unix time parser.
// Used by every module of the parser; has no dependencies of its own.
package isoep_pkg;

   // Field widths
   localparam int unsigned PosW    = 5;
   localparam int unsigned YearW   = 14;
   localparam int unsigned FieldW  = 7;
   localparam int unsigned CharW   = 8;
   localparam int unsigned DoyW    = 9;
   localparam int unsigned DdW     = 10;
   localparam int unsigned TodW    = 17;
   localparam int unsigned DaysW   = 22;
   localparam int unsigned SumW    = 24;
   localparam int unsigned EpochW  = 38;

   // Default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Character positions of the fixed text layout
   localparam logic [PosW-1:0] POS_DASH_A  = 5'd4;
   localparam logic [PosW-1:0] POS_DASH_B  = 5'd7;
   localparam logic [PosW-1:0] POS_T       = 5'd10;
   localparam logic [PosW-1:0] POS_COLON_A = 5'd13;
   localparam logic [PosW-1:0] POS_COLON_B = 5'd16;
   localparam logic [PosW-1:0] TS_LEN      = 5'd19;

   // ASCII codes
   localparam logic [CharW-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [CharW-1:0] CHAR_T     = 8'h54;
   localparam logic [CharW-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CharW-1:0] CHAR_NINE  = 8'h39;

   // Range limits
   localparam logic [YearW-1:0]  YEAR_MIN   = 14'd1970;
   localparam logic [FieldW-1:0] MONTH_FEB  = 7'd2;
   localparam logic [FieldW-1:0] MONTH_MAX  = 7'd12;
   localparam logic [FieldW-1:0] DAY_MAX    = 7'd31;
   localparam logic [FieldW-1:0] HOUR_MAX   = 7'd23;
   localparam logic [FieldW-1:0] MINUTE_MAX = 7'd59;
   localparam logic [FieldW-1:0] SECOND_MAX = 7'd60;

   // Calendar arithmetic: x / 25 as (x * 1311) >> 15, exact for x below 4096
   localparam logic [10:0]     RECIP25     = 11'd1311;
   localparam int unsigned     RECIP_SHIFT = 15;
   localparam logic [8:0]      DAYS_PER_YEAR = 9'd365;
   // Day number of 1970-01-01 in the March-based count, plus one for the 1-based day
   localparam logic [SumW-1:0] DAYS_BIAS   = 24'd719469;
   localparam logic [TodW-1:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [11:0]     SECS_PER_HOUR = 12'd3600;
   localparam logic [5:0]      SECS_PER_MIN  = 6'd60;

   // One parsed timestamp handed from front to back
   typedef struct packed {
      logic [YearW-1:0]  year;
      logic [FieldW-1:0] month;
      logic [FieldW-1:0] day;
      logic [FieldW-1:0] hour;
      logic [FieldW-1:0] minute;
      logic [FieldW-1:0] second;
      logic              ok;
   } fields_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic nonempty;
   } qstat_type;

   // Days from March 1 to the first of the given month (March-based year)
   function automatic logic [DoyW-1:0] doy_of_month(input logic [FieldW-1:0] month);
      logic [DoyW-1:0] doy;
      begin
         case (month)
            7'd3:    doy = 9'd0;
            7'd4:    doy = 9'd31;
            7'd5:    doy = 9'd61;
            7'd6:    doy = 9'd92;
            7'd7:    doy = 9'd122;
            7'd8:    doy = 9'd153;
            7'd9:    doy = 9'd184;
            7'd10:   doy = 9'd214;
            7'd11:   doy = 9'd245;
            7'd12:   doy = 9'd275;
            7'd1:    doy = 9'd306;
            7'd2:    doy = 9'd337;
            default: doy = 9'd0;
         endcase
         return doy;
      end
   endfunction

endpackage

// File: design/isoep_front.sv
`timescale 1ns / 1ps
// Front of the parser: takes one character per transfer, checks the layout and
// accumulates the date and time fields. Depends on isoep_pkg.
module isoep_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [isoep_pkg::CharW-1:0]   req_char_code,
   input  logic                          req_last_char,
   input  isoep_pkg::qstat_type          qstat,
   output logic                          push,
   output isoep_pkg::fields_type         push_data
);

   logic [isoep_pkg::PosW-1:0]   pos_ff, pos_in, pos_upd;
   logic [isoep_pkg::YearW-1:0]  year_ff, year_in, year_upd;
   logic [isoep_pkg::FieldW-1:0] month_ff, month_in, month_upd;
   logic [isoep_pkg::FieldW-1:0] day_ff, day_in, day_upd;
   logic [isoep_pkg::FieldW-1:0] hour_ff, hour_in, hour_upd;
   logic [isoep_pkg::FieldW-1:0] minute_ff, minute_in, minute_upd;
   logic [isoep_pkg::FieldW-1:0] second_ff, second_in, second_upd;
   logic                         err_ff, err_in, err_upd;
   logic                         accept;
   logic                         is_digit;
   logic [3:0]                   digit;
   logic [17:0]                  year_mul;

   // Only a last character needs a queue slot
   assign req_stall = qstat.full & req_last_char;
   assign accept    = req_valid & ~req_stall;
   assign push      = accept & req_last_char;

   assign is_digit = (req_char_code >= isoep_pkg::CHAR_ZERO) &&
                     (req_char_code <= isoep_pkg::CHAR_NINE);
   assign digit    = is_digit ? 4'(req_char_code - isoep_pkg::CHAR_ZERO) : 4'd0;
   assign year_mul = {4'd0, year_ff} * 18'd10 + {14'd0, digit};

   // Classify the character and advance the accumulators
   always_comb begin
      pos_upd    = pos_ff;
      year_upd   = year_ff;
      month_upd  = month_ff;
      day_upd    = day_ff;
      hour_upd   = hour_ff;
      minute_upd = minute_ff;
      second_upd = second_ff;
      err_upd    = err_ff;
      if (pos_ff < isoep_pkg::TS_LEN) begin
         if (pos_ff == isoep_pkg::POS_DASH_A || pos_ff == isoep_pkg::POS_DASH_B) begin
            if (req_char_code != isoep_pkg::CHAR_DASH) err_upd = 1'b1;
         end else if (pos_ff == isoep_pkg::POS_T) begin
            if (req_char_code != isoep_pkg::CHAR_T) err_upd = 1'b1;
         end else if (pos_ff == isoep_pkg::POS_COLON_A || pos_ff == isoep_pkg::POS_COLON_B) begin
            if (req_char_code != isoep_pkg::CHAR_COLON) err_upd = 1'b1;
         end else if (!is_digit) begin
            err_upd = 1'b1;
         end else if (pos_ff < isoep_pkg::POS_DASH_A) begin
            year_upd = year_mul[isoep_pkg::YearW-1:0];
         end else if (pos_ff < isoep_pkg::POS_DASH_B) begin
            month_upd = 7'(month_ff * 7'd10 + {3'd0, digit});
         end else if (pos_ff < isoep_pkg::POS_T) begin
            day_upd = 7'(day_ff * 7'd10 + {3'd0, digit});
         end else if (pos_ff < isoep_pkg::POS_COLON_A) begin
            hour_upd = 7'(hour_ff * 7'd10 + {3'd0, digit});
         end else if (pos_ff < isoep_pkg::POS_COLON_B) begin
            minute_upd = 7'(minute_ff * 7'd10 + {3'd0, digit});
         end else begin
            second_upd = 7'(second_ff * 7'd10 + {3'd0, digit});
         end
         pos_upd = pos_ff + 5'd1;
      end
   end

   // Build the queue record from the updated fields
   always_comb begin
      push_data.year   = year_upd;
      push_data.month  = month_upd;
      push_data.day    = day_upd;
      push_data.hour   = hour_upd;
      push_data.minute = minute_upd;
      push_data.second = second_upd;
      push_data.ok     = (pos_upd >= isoep_pkg::TS_LEN) && !err_upd &&
                         (year_upd >= isoep_pkg::YEAR_MIN) &&
                         (month_upd != 7'd0) && (month_upd <= isoep_pkg::MONTH_MAX) &&
                         (day_upd != 7'd0) && (day_upd <= isoep_pkg::DAY_MAX) &&
                         (hour_upd <= isoep_pkg::HOUR_MAX) &&
                         (minute_upd <= isoep_pkg::MINUTE_MAX) &&
                         (second_upd <= isoep_pkg::SECOND_MAX);
   end

   // Commit on a transfer; clear after the last character
   always_comb begin
      pos_in    = pos_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      err_in    = err_ff;
      if (accept) begin
         if (req_last_char) begin
            pos_in    = '0;
            year_in   = '0;
            month_in  = '0;
            day_in    = '0;
            hour_in   = '0;
            minute_in = '0;
            second_in = '0;
            err_in    = 1'b0;
         end else begin
            pos_in    = pos_upd;
            year_in   = year_upd;
            month_in  = month_upd;
            day_in    = day_upd;
            hour_in   = hour_upd;
            minute_in = minute_upd;
            second_in = second_upd;
            err_in    = err_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         err_ff    <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         err_ff    <= err_in;
      end
   end

endmodule

// File: design/isoep_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of parsed timestamps between front and back.
// Depends on isoep_pkg.
module isoep_queue #(
   parameter int unsigned Depth = isoep_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  isoep_pkg::fields_type push_data,
   input  logic                  pop,
   output isoep_pkg::fields_type head,
   output isoep_pkg::qstat_type  qstat
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   isoep_pkg::fields_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign head           = entry_ff[rd_ptr_ff];
   assign qstat.full     = (count_ff == FullCnt);
   assign qstat.nonempty = (count_ff != '0);

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      if (push && !pop)      count_in = count_ff + CntW'(1);
      else if (pop && !push) count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the record
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: design/isoep_back.sv
`timescale 1ns / 1ps
// Back of the parser: three-stage conversion of a parsed timestamp to Unix
// seconds, ending in the result register. Depends on isoep_pkg.
module isoep_back (
   input  logic                          clock,
   input  logic                          reset,
   input  isoep_pkg::qstat_type          qstat,
   input  isoep_pkg::fields_type         head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [isoep_pkg::EpochW-1:0]  rsp_epoch_seconds,
   output logic                          rsp_parse_ok
);

   // Stage valids and ready chain
   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic out_v_ff, out_v_in;
   logic out_rdy, s2_rdy, s1_rdy;

   // Stage 1 results
   logic [isoep_pkg::YearW-1:0] yy;
   logic [11:0]                 q4;
   logic [22:0]                 q100_mul;
   logic [20:0]                 q400_mul;
   logic [isoep_pkg::DdW-1:0]   dd;
   logic [isoep_pkg::TodW-1:0]  tod;
   logic [isoep_pkg::YearW-1:0] yy_ff;
   logic [11:0]                 q4_ff;
   logic [7:0]                  q100_ff;
   logic [5:0]                  q400_ff;
   logic [isoep_pkg::DdW-1:0]   dd_ff;
   logic [isoep_pkg::TodW-1:0]  tod1_ff;
   logic                        ok1_ff;

   // Stage 2 results
   logic [22:0]                 yday_mul;
   logic [isoep_pkg::SumW-1:0]  days_sum;
   logic [isoep_pkg::DaysW-1:0] days_ff;
   logic [isoep_pkg::TodW-1:0]  tod2_ff;
   logic                        ok2_ff;

   // Stage 3 results
   logic [38:0]                 secs_mul;
   logic [isoep_pkg::EpochW-1:0] epoch_ff, epoch_in;
   logic                        ok3_ff;

   assign out_rdy = ~out_v_ff | ~rsp_stall;
   assign s2_rdy  = ~s2_v_ff | out_rdy;
   assign s1_rdy  = ~s1_v_ff | s2_rdy;
   assign pop     = qstat.nonempty & s1_rdy;

   assign s1_v_in  = s1_rdy ? qstat.nonempty : s1_v_ff;
   assign s2_v_in  = s2_rdy ? s1_v_ff : s2_v_ff;
   assign out_v_in = out_rdy ? s2_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Stage 1: March-based year, century terms, day of year, time of day
   always_comb begin
      yy = (head.month <= isoep_pkg::MONTH_FEB) ? head.year - 14'd1 : head.year;
      q4 = yy[isoep_pkg::YearW-1:2];
      q100_mul = {11'd0, q4} * {12'd0, isoep_pkg::RECIP25};
      q400_mul = {11'd0, yy[isoep_pkg::YearW-1:4]} * {10'd0, isoep_pkg::RECIP25};
      dd  = {1'b0, isoep_pkg::doy_of_month(head.month)} + {3'd0, head.day};
      tod = ({10'd0, head.hour} * {5'd0, isoep_pkg::SECS_PER_HOUR})
          + 17'({6'd0, head.minute} * {7'd0, isoep_pkg::SECS_PER_MIN})
          + {10'd0, head.second};
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         yy_ff   <= yy;
         q4_ff   <= q4;
         q100_ff <= q100_mul[isoep_pkg::RECIP_SHIFT +: 8];
         q400_ff <= q400_mul[isoep_pkg::RECIP_SHIFT +: 6];
         dd_ff   <= dd;
         tod1_ff <= tod;
         ok1_ff  <= head.ok;
      end
   end

   // Stage 2: day count since the epoch
   assign yday_mul = {9'd0, yy_ff} * {14'd0, isoep_pkg::DAYS_PER_YEAR};
   assign days_sum = {1'b0, yday_mul} + {12'd0, q4_ff} + {18'd0, q400_ff}
                   + {14'd0, dd_ff} - {16'd0, q100_ff} - isoep_pkg::DAYS_BIAS;

   always_ff @(posedge clock) begin
      if (s1_v_ff && s2_rdy) begin
         days_ff <= ok1_ff ? days_sum[isoep_pkg::DaysW-1:0] : '0;
         tod2_ff <= ok1_ff ? tod1_ff : '0;
         ok2_ff  <= ok1_ff;
      end
   end

   // Stage 3: scale days to seconds and add time of day
   assign secs_mul = {17'd0, days_ff} * {22'd0, isoep_pkg::SECS_PER_DAY};
   assign epoch_in = secs_mul[isoep_pkg::EpochW-1:0] + {21'd0, tod2_ff};

   always_ff @(posedge clock) begin
      if (s2_v_ff && out_rdy) begin
         epoch_ff <= epoch_in;
         ok3_ff   <= ok2_ff;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_epoch_seconds = epoch_ff;
   assign rsp_parse_ok      = ok3_ff;

endmodule

// File: design/iso8601_to_epoch_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the ISO 8601 timestamp to Unix time parser.
// Instantiates isoep_front, isoep_queue and isoep_back; depends on isoep_pkg.

// The block takes the text YYYY-MM-DDThh:mm:ss one byte per transfer and
// accepts a byte every cycle unless stalled. Only a byte marked last produces
// a result: Unix seconds since 1970-01-01T00:00:00 UTC with parse_ok set, or
// zero with parse_ok clear when the string was short, misformatted or out of
// range. Bytes after the nineteenth are ignored. A day past the month's end
// rolls into the next month and second 60 into the next minute. The front
// checks and accumulates each byte as it is taken; the parsed fields of a
// finished string wait in a queue (QueueDepth entries, two by default) while
// the back converts them in three registered stages, the last being the
// result register. With no stall on the result side, one string may finish
// every cycle. A last byte is stalled only while the queue is full.
module iso8601_to_epoch_parser_unit #(
   parameter int unsigned QueueDepth = isoep_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [isoep_pkg::CharW-1:0]   req_char_code,
   input  logic                          req_last_char,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [isoep_pkg::EpochW-1:0]  rsp_epoch_seconds,
   output logic                          rsp_parse_ok
);

   isoep_pkg::qstat_type  qstat;
   isoep_pkg::fields_type push_data;
   isoep_pkg::fields_type head;
   logic                  push;
   logic                  pop;

   isoep_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .qstat         (qstat),
      .push          (push),
      .push_data     (push_data)
   );

   isoep_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .qstat     (qstat)
   );

   isoep_back u_back (
      .clock             (clock),
      .reset             (reset),
      .qstat             (qstat),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_parse_ok      (rsp_parse_ok)
   );

endmodule

// File: design/isoep_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ISO 8601 timestamp parser, bound to the top level.
// Depends on isoep_pkg and iso8601_to_epoch_parser_unit.
module isoep_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_last_char,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [isoep_pkg::EpochW-1:0]  rsp_epoch_seconds,
   input logic                          rsp_parse_ok
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_epoch_seconds) &&
                                 $stable(rsp_parse_ok))
      else $error("stalled result changed");

   // Drive zero seconds on a failed parse
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_parse_ok |-> rsp_epoch_seconds == '0)
      else $error("failed parse with nonzero seconds");

   // Never stall a byte that is not the last one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_last_char |-> !req_stall)
      else $error("non-last byte stalled");

   // Keep a good result at or below the end of year 9999
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_ok |-> rsp_epoch_seconds <= 38'd253402300800)
      else $error("seconds out of range");

   // Drop the valid only after a transfer
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> !$past(rsp_stall))
      else $error("result lost");

endmodule

bind iso8601_to_epoch_parser_unit isoep_checker u_isoep_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_last_char     (req_last_char),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_epoch_seconds (rsp_epoch_seconds),
   .rsp_parse_ok      (rsp_parse_ok)
);

// File: tb/sv/iso8601_to_epoch_parser_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for iso8601_to_epoch_parser_unit: sends timestamp text byte by byte,
// predicts each Unix-seconds result on its own and compares. Depends on isoep_pkg and the RTL.
module iso8601_to_epoch_parser_unit_test;

   typedef logic [isoep_pkg::CharW-1:0]  char_type;
   typedef logic [isoep_pkg::EpochW-1:0] secs_type;
   typedef logic [isoep_pkg::PosW-1:0]   pos_type;
   typedef logic [isoep_pkg::YearW-1:0]  year_type;
   typedef logic [isoep_pkg::FieldW-1:0] field_type;

   typedef struct packed {
      secs_type secs;
      logic     ok;
   } epoch_result_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   char_type  req_char_code;
   logic      req_last_char;
   logic      rsp_valid;
   logic      rsp_stall;
   secs_type  rsp_epoch_seconds;
   logic      rsp_parse_ok;

   // Predictor state: one timestamp being parsed
   pos_type   ts_pos;
   year_type  ts_year;
   field_type ts_month;
   field_type ts_day;
   field_type ts_hour;
   field_type ts_minute;
   field_type ts_second;
   logic      ts_bad;

   epoch_result_type pending_stamps[$];

   int  mismatch_count = 0;
   int  result_count   = 0;
   int  valid_count    = 0;
   int  live_bytes     = 0;
   int  sent_bytes     = 0;
   int  hold_cycles    = 0;
   bit  send_gaps_on   = 1'b1;
   bit  stall_gaps_on  = 1'b1;

   iso8601_to_epoch_parser_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_last_char     (req_last_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_parse_ok      (rsp_parse_ok)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Unix seconds of a range-checked date and time; days counted in March-based years
   function automatic longint stamp_to_epoch(longint y, longint m, longint d,
                                             longint hh, longint mi, longint ss);
      longint yy, era, yoe, mp, doy, doe, days;
      yy   = (m <= 2) ? y - 1 : y;
      era  = yy / 400;
      yoe  = yy - era * 400;
      mp   = (m > 2) ? m - 3 : m + 9;
      doy  = (153 * mp + 2) / 5;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468 + d - 1;
      return days * 86400 + hh * 3600 + mi * 60 + ss;
   endfunction

   // Advance the parse state by one accepted byte; queue a result on the last byte
   task automatic parse_predict_byte(input char_type code, input logic last);
      logic             is_digit;
      logic [3:0]       digit;
      epoch_result_type res;
      is_digit = (code >= isoep_pkg::CHAR_ZERO) && (code <= isoep_pkg::CHAR_NINE);
      digit    = is_digit ? 4'(code - isoep_pkg::CHAR_ZERO) : 4'd0;
      if (ts_pos < isoep_pkg::TS_LEN) begin
         live_bytes++;
         case (ts_pos)
            isoep_pkg::POS_DASH_A, isoep_pkg::POS_DASH_B: begin
               if (code != isoep_pkg::CHAR_DASH) ts_bad = 1'b1;
            end
            isoep_pkg::POS_T: begin
               if (code != isoep_pkg::CHAR_T) ts_bad = 1'b1;
            end
            isoep_pkg::POS_COLON_A, isoep_pkg::POS_COLON_B: begin
               if (code != isoep_pkg::CHAR_COLON) ts_bad = 1'b1;
            end
            default: begin
               if (!is_digit) ts_bad = 1'b1;
               else if (ts_pos < isoep_pkg::POS_DASH_A)
                  ts_year = year_type'(ts_year * 10 + digit);
               else if (ts_pos < isoep_pkg::POS_DASH_B)
                  ts_month = field_type'(ts_month * 10 + digit);
               else if (ts_pos < isoep_pkg::POS_T)
                  ts_day = field_type'(ts_day * 10 + digit);
               else if (ts_pos < isoep_pkg::POS_COLON_A)
                  ts_hour = field_type'(ts_hour * 10 + digit);
               else if (ts_pos < isoep_pkg::POS_COLON_B)
                  ts_minute = field_type'(ts_minute * 10 + digit);
               else
                  ts_second = field_type'(ts_second * 10 + digit);
            end
         endcase
         ts_pos = ts_pos + pos_type'(1);
      end
      if (last) begin
         res.ok = (ts_pos >= isoep_pkg::TS_LEN) && !ts_bad
            && (ts_year >= isoep_pkg::YEAR_MIN)
            && (ts_month >= 1) && (ts_month <= isoep_pkg::MONTH_MAX)
            && (ts_day >= 1) && (ts_day <= isoep_pkg::DAY_MAX)
            && (ts_hour <= isoep_pkg::HOUR_MAX) && (ts_minute <= isoep_pkg::MINUTE_MAX)
            && (ts_second <= isoep_pkg::SECOND_MAX);
         res.secs = res.ok ? secs_type'(stamp_to_epoch(ts_year, ts_month, ts_day,
                                                       ts_hour, ts_minute, ts_second)) : '0;
         pending_stamps.insert(pending_stamps.size(), res);
         ts_pos    = '0;
         ts_year   = '0;
         ts_month  = '0;
         ts_day    = '0;
         ts_hour   = '0;
         ts_minute = '0;
         ts_second = '0;
         ts_bad    = 1'b0;
      end
   endtask

   // Offer one byte, with an optional idle burst first; returns at the next falling edge
   task automatic send_byte(input char_type code, input logic last);
      int gap;
      if (send_gaps_on && $urandom_range(5, 0) == 0) begin
         gap = $urandom_range(15, 1);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      req_last_char <= last;
      do @(posedge clock); while (req_stall);
      sent_bytes++;
      parse_predict_byte(code, last);
      @(negedge clock);
   endtask

   task automatic send_bytes(input char_type txt[$]);
      foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
   endtask

   // Send text, optionally with one byte replaced (negative position keeps it intact)
   task automatic send_text(input string s, input int at = -1,
                            input char_type code = '0);
      char_type txt[$];
      for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
      if (at >= 0) txt[at] = code;
      send_bytes(txt);
   endtask

   // Stop offering bytes until every expected result has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_stamps.size() != 0) @(negedge clock);
   endtask

   // Mostly in range, now and then anything the digits allow
   function automatic int pick_field(int lo, int hi, int wild_hi);
      if ($urandom_range(9, 0) != 0) return $urandom_range(hi, lo);
      return $urandom_range(wild_hi, 0);
   endfunction

   // One random timestamp: mostly well-formed, some corrupted, cut short, padded or noise
   task automatic send_random_stamp();
      char_type txt[$];
      string s;
      int yr, kind, keep;
      case ($urandom_range(7, 0))
         0:       yr = 1970;
         1:       yr = 9999;
         2:       yr = $urandom_range(1969, 0);
         3:       yr = 100 * $urandom_range(99, 20);
         default: yr = $urandom_range(2200, 1970);
      endcase
      s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", yr, pick_field(1, 12, 99),
                    pick_field(1, 31, 99), pick_field(0, 23, 99),
                    pick_field(0, 59, 99), pick_field(0, 60, 99));
      for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
      kind = $urandom_range(19, 0);
      if (kind < 2) begin
         txt[$urandom_range(18, 0)] = char_type'($urandom_range(255, 0));
      end else if (kind == 2) begin
         keep = $urandom_range(18, 1);
         while (txt.size() > keep) void'(txt.pop_back());
      end else if (kind == 3) begin
         repeat ($urandom_range(6, 1))
            txt.insert(txt.size(), char_type'($urandom_range(255, 0)));
      end else if (kind == 4) begin
         txt.delete();
         repeat ($urandom_range(25, 1))
            txt.insert(txt.size(), char_type'($urandom_range(255, 0)));
      end
      send_bytes(txt);
   endtask

   // Edge dates, leap second and month rollover
   task automatic test_calendar_extremes();
      send_text("1970-01-01T00:00:00");
      send_text("9999-12-31T23:59:59");
      send_text("9999-12-31T23:59:60");
      send_text("2016-12-31T23:59:60");
      send_text("2021-02-31T12:34:56");
      send_text("2020-02-31T00:00:00");
      send_text("2000-02-29T23:59:59");
      send_text("2100-03-01T00:00:00");
   endtask

   // Each field just past its limit
   task automatic test_range_limits();
      send_text("1969-12-31T23:59:59");
      send_text("2000-00-10T00:00:00");
      send_text("2000-13-10T00:00:00");
      send_text("2000-01-00T00:00:00");
      send_text("2000-01-32T00:00:00");
      send_text("2000-01-01T24:00:00");
      send_text("2000-01-01T00:60:00");
      send_text("2000-01-01T00:00:61");
   endtask

   // Wrong separators and non-digits, including bytes next to the digit range
   task automatic test_format_checks();
      send_text("2000-01-01T00:00:00", 4, "/");
      send_text("2000-01-01T00:00:00", 7, 8'h00);
      send_text("2000-01-01T00:00:00", 10, " ");
      send_text("2000-01-01T00:00:00", 13, 8'hFF);
      send_text("2000-01-01T00:00:00", 16, "-");
      send_text("2000-01-01T00:00:00", 0, 8'h2F);
      send_text("2000-01-01T00:00:00", 18, 8'h3A);
      send_text("2000-01-01T00:00:00", 12, "T");
   endtask

   // Short strings end early; anything past the nineteenth byte is ignored
   task automatic test_short_and_trailing();
      send_text("2000-01-01");
      send_text("2");
      send_text("2000-01-01T00:00:00Z");
      send_text("2023-06-15T08:30:45.123+01:00");
      send_text("2023-06-15T08:30:45..", 19, 8'h00);
      send_text("2023-06-15T08:30:45..", 20, 8'hFF);
   endtask

   // Hold the result side for a long stretch while strings keep coming, then pause
   task automatic test_backpressure();
      send_gaps_on = 1'b0;
      hold_cycles  = 250;
      repeat (8) send_random_stamp();
      repeat (12) send_byte(char_type'($urandom_range(255, 0)), 1'b1);
      wait_drained();
      repeat (4) send_random_stamp();
      send_gaps_on = 1'b1;
   endtask

   // Random strings with idling switched on and off on either side
   task automatic test_random_stamps();
      while (sent_bytes < 830) begin
         if ($urandom_range(9, 0) == 0) send_gaps_on = ~send_gaps_on;
         if ($urandom_range(9, 0) == 0) stall_gaps_on = ~stall_gaps_on;
         send_random_stamp();
      end
   endtask

   // No idling at all: one single-byte string finishing every cycle, then whole stamps
   task automatic test_back_to_back();
      send_gaps_on  = 1'b0;
      stall_gaps_on = 1'b0;
      repeat (12) send_byte(char_type'($urandom_range(255, 0)), 1'b1);
      repeat (6) send_random_stamp();
   endtask

   // Result-side stall: long hold on request, else random bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (stall_gaps_on && $urandom_range(5, 0) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(15, 1)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each transfer on the result side with the oldest expectation
   always @(posedge clock) begin : check_results
      epoch_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (rsp_parse_ok) valid_count++;
         if (pending_stamps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: secs=%0d ok=%0b", rsp_epoch_seconds, rsp_parse_ok);
         end else begin
            want = pending_stamps.pop_front();
            if (rsp_epoch_seconds !== want.secs || rsp_parse_ok !== want.ok) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected secs=%0d ok=%0b, got secs=%0d ok=%0b",
                           want.secs, want.ok, rsp_epoch_seconds, rsp_parse_ok);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_stamps.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_code = '0;
      req_last_char = 1'b0;
      ts_pos    = '0;
      ts_year   = '0;
      ts_month  = '0;
      ts_day    = '0;
      ts_hour   = '0;
      ts_minute = '0;
      ts_second = '0;
      ts_bad    = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_calendar_extremes();
      test_range_limits();
      test_format_checks();
      test_short_and_trailing();
      test_backpressure();
      test_random_stamps();
      test_back_to_back();

      wait_drained();
      repeat (16) @(negedge clock);

      $display("Sent %0d bytes (%0d checked) into %0d results, %0d of them valid timestamps.",
               sent_bytes, live_bytes, result_count, valid_count);
      $display("Covered edge dates, range and format errors, short and padded text, stalls.");
      if (mismatch_count == 0 && pending_stamps.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, pending_stamps.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
design/isoep_pkg.sv
design/isoep_front.sv
design/isoep_queue.sv
design/isoep_back.sv
design/iso8601_to_epoch_parser_unit.sv
design/isoep_checker.sv
tb/sv/iso8601_to_epoch_parser_unit_test.sv
